// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/pexa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pexa_pkg;

	localparam int unsigned WORD_W = 64;
	localparam int unsigned REG_W  = 4;
	localparam int unsigned CODE_W = 4;

	// Opcodes
	localparam logic [CODE_W-1:0] OP_CMOV  = 4'd2;
	localparam logic [CODE_W-1:0] OP_IRMOV = 4'd3;
	localparam logic [CODE_W-1:0] OP_RMMOV = 4'd4;
	localparam logic [CODE_W-1:0] OP_MRMOV = 4'd5;
	localparam logic [CODE_W-1:0] OP_ALU   = 4'd6;
	localparam logic [CODE_W-1:0] OP_JUMP  = 4'd7;
	localparam logic [CODE_W-1:0] OP_CALL  = 4'd8;
	localparam logic [CODE_W-1:0] OP_RET   = 4'd9;
	localparam logic [CODE_W-1:0] OP_PUSH  = 4'd10;
	localparam logic [CODE_W-1:0] OP_POP   = 4'd11;

	// ALU function codes
	localparam logic [CODE_W-1:0] FN_ADD = 4'd0;
	localparam logic [CODE_W-1:0] FN_SUB = 4'd1;
	localparam logic [CODE_W-1:0] FN_AND = 4'd2;
	localparam logic [CODE_W-1:0] FN_XOR = 4'd3;

	// Condition codes
	localparam logic [CODE_W-1:0] CC_ALWAYS = 4'd0;
	localparam logic [CODE_W-1:0] CC_LE     = 4'd1;
	localparam logic [CODE_W-1:0] CC_L      = 4'd2;
	localparam logic [CODE_W-1:0] CC_E      = 4'd3;
	localparam logic [CODE_W-1:0] CC_NE     = 4'd4;
	localparam logic [CODE_W-1:0] CC_GE     = 4'd5;
	localparam logic [CODE_W-1:0] CC_G      = 4'd6;

	localparam logic [REG_W-1:0]  REG_NONE   = 4'd15;
	localparam logic [WORD_W-1:0] STACK_UP   = 64'd8;
	localparam logic [WORD_W-1:0] STACK_DOWN = 64'hFFFF_FFFF_FFFF_FFF8;

	typedef struct packed {
		logic [CODE_W-1:0] opcode;
		logic [CODE_W-1:0] func_code;
		logic [WORD_W-1:0] reg_value_a;
		logic [WORD_W-1:0] reg_value_b;
		logic [WORD_W-1:0] const_word;
		logic [REG_W-1:0]  dest_in;
		logic              hold_flags;
	} item_t;

	typedef struct packed {
		logic zero;
		logic sign;
		logic overflow;
	} flags_t;

	typedef struct packed {
		logic [WORD_W-1:0] alu_result;
		logic              cond_true;
		logic [REG_W-1:0]  dest_out;
		flags_t            flags;
	} result_t;

endpackage

`default_nettype wire

// File: hw/rtl/pexa_insn_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pexa_insn_if;
	logic        valid;
	logic        ready;
	logic [3:0]  opcode;
	logic [3:0]  func_code;
	logic [63:0] reg_value_a;
	logic [63:0] reg_value_b;
	logic [63:0] const_word;
	logic [3:0]  dest_in;
	logic        hold_flags;

	modport source (
		output valid, opcode, func_code, reg_value_a, reg_value_b, const_word,
			dest_in, hold_flags,
		input  ready
	);
	modport sink (
		input  valid, opcode, func_code, reg_value_a, reg_value_b, const_word,
			dest_in, hold_flags,
		output ready
	);
endinterface

`default_nettype wire

// File: hw/rtl/pexa_res_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pexa_res_if;
	logic        valid;
	logic        ready;
	logic [63:0] alu_result;
	logic        cond_true;
	logic [3:0]  dest_out;
	logic        zero_out;
	logic        sign_out;
	logic        overflow_out;

	modport source (
		output valid, alu_result, cond_true, dest_out, zero_out, sign_out, overflow_out,
		input  ready
	);
	modport sink (
		input  valid, alu_result, cond_true, dest_out, zero_out, sign_out, overflow_out,
		output ready
	);
endinterface

`default_nettype wire

// File: hw/rtl/pexa_alu.sv
`timescale 1ns / 1ps
`default_nettype none

module pexa_alu (
	input  pexa_pkg::item_t   item,
	input  pexa_pkg::flags_t  flags_cur,
	output pexa_pkg::result_t result,
	output pexa_pkg::flags_t  flags_nxt
);
	import pexa_pkg::*;

	logic [WORD_W-1:0] op_a;
	logic [WORD_W-1:0] op_b;
	logic [CODE_W-1:0] fn;
	logic              is_sub;
	logic [WORD_W-1:0] sum;
	logic [WORD_W-1:0] alu_r;
	logic              ovf;
	logic              lt;
	logic              cond;
	logic              upd;

	// Operand select
	always_comb begin
		case (item.opcode)
			OP_CMOV, OP_ALU:             op_a = item.reg_value_a;
			OP_IRMOV, OP_RMMOV, OP_MRMOV: op_a = item.const_word;
			OP_CALL, OP_PUSH:            op_a = STACK_DOWN;
			OP_RET, OP_POP:              op_a = STACK_UP;
			default:                     op_a = '0;
		endcase
		case (item.opcode)
			OP_RMMOV, OP_MRMOV, OP_ALU, OP_CALL, OP_RET, OP_PUSH, OP_POP:
				op_b = item.reg_value_b;
			default:
				op_b = '0;
		endcase
	end

	assign fn     = (item.opcode == OP_ALU) ? item.func_code : FN_ADD;
	assign is_sub = (fn == FN_SUB);
	// one shared adder: b - a as b + ~a + 1
	assign sum    = op_b + (is_sub ? ~op_a : op_a) + {{(WORD_W-1){1'b0}}, is_sub};

	always_comb begin
		case (fn)
			FN_ADD:  begin
				alu_r = sum;
				ovf   = (op_a[WORD_W-1] == op_b[WORD_W-1]) && (sum[WORD_W-1] != op_a[WORD_W-1]);
			end
			FN_SUB:  begin
				alu_r = sum;
				ovf   = (op_b[WORD_W-1] != op_a[WORD_W-1]) && (sum[WORD_W-1] != op_b[WORD_W-1]);
			end
			FN_AND:  begin
				alu_r = op_b & op_a;
				ovf   = 1'b0;
			end
			FN_XOR:  begin
				alu_r = op_b ^ op_a;
				ovf   = 1'b0;
			end
			default: begin
				alu_r = '0;
				ovf   = 1'b0;
			end
		endcase
	end

	assign upd = (item.opcode == OP_ALU) && !item.hold_flags;

	always_comb begin
		if (upd) begin
			flags_nxt.zero     = (alu_r == '0);
			flags_nxt.sign     = alu_r[WORD_W-1];
			flags_nxt.overflow = ovf;
		end else begin
			flags_nxt = flags_cur;
		end
	end

	// Branch / cmov condition from the flags held before this item
	assign lt = flags_cur.sign ^ flags_cur.overflow;

	always_comb begin
		case (item.func_code)
			CC_ALWAYS: cond = 1'b1;
			CC_LE:     cond = lt || flags_cur.zero;
			CC_L:      cond = lt;
			CC_E:      cond = flags_cur.zero;
			CC_NE:     cond = !flags_cur.zero;
			CC_GE:     cond = !lt;
			CC_G:      cond = !lt && !flags_cur.zero;
			default:   cond = 1'b0;
		endcase
	end

	always_comb begin
		result.alu_result = alu_r;
		result.cond_true  = ((item.opcode == OP_JUMP) || (item.opcode == OP_CMOV)) && cond;
		result.dest_out   = ((item.opcode == OP_CMOV) && !cond) ? REG_NONE : item.dest_in;
		result.flags      = flags_nxt;
	end

endmodule

`default_nettype wire

// File: hw/rtl/pipeline_execute_alu_cc.sv
// Execute stage (ALU and condition codes) of a five-stage 64-bit pipeline.
// Channel insn (sink): one instruction per item -- opcode, function code,
//   two register values, constant word, destination and a flag-hold bit.
// Channel res (source): one item per instruction -- ALU result, condition
//   outcome, destination (cancelled to 15 on a failed cmov) and the zero,
//   sign and overflow flags as they stand after the instruction.
// Structure: input register (_s1), then one pass through the operand mux,
//   a single 64-bit adder / logic unit and the condition evaluator, into the
//   result register (_s2). The flags live in flag_q and are written in the
//   same cycle the instruction moves from s1 to s2, so each instruction sees
//   the flags left by the one before it.
// Order: an accepted instruction is registered in s1, then in s2 when s1
//   advances; res.valid is high while s2 holds it.
// Throughput: one item per cycle while res keeps taking results.
// Stall: when res is not taken, s2 holds; s1 fills and then insn.ready drops.
//   insn.ready stays high while s1 is empty or moves on in the same cycle.
// Reset (arst_n low): both stages empty, all three flags cleared.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module pipeline_execute_alu_cc (
	input  wire          clk,
	input  wire          arst_n,
	pexa_insn_if.sink    insn,
	pexa_res_if.source   res
);
	import pexa_pkg::*;

	item_t   item_s1;
	logic    valid_s1;
	result_t res_s2;
	logic    valid_s2;
	flags_t  flag_q;

	result_t res_nxt;
	flags_t  flag_nxt;
	logic    advance;
	logic    insn_fire;

	// s1 moves on whenever the result register is free or being drained
	assign advance   = valid_s1 && (!valid_s2 || res.ready);
	assign insn.ready = !valid_s1 || advance;
	assign insn_fire = insn.valid && insn.ready;

	pexa_alu u_alu (
		.item      (item_s1),
		.flags_cur (flag_q),
		.result    (res_nxt),
		.flags_nxt (flag_nxt)
	);

	// control and architectural flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			flag_q   <= '0;
		end else begin
			if (insn_fire)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;

			if (advance)
				valid_s2 <= 1'b1;
			else if (res.ready)
				valid_s2 <= 1'b0;

			if (advance)
				flag_q <= flag_nxt;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (insn_fire) begin
			item_s1.opcode      <= insn.opcode;
			item_s1.func_code   <= insn.func_code;
			item_s1.reg_value_a <= insn.reg_value_a;
			item_s1.reg_value_b <= insn.reg_value_b;
			item_s1.const_word  <= insn.const_word;
			item_s1.dest_in     <= insn.dest_in;
			item_s1.hold_flags  <= insn.hold_flags;
		end
		if (advance)
			res_s2 <= res_nxt;
	end

	assign res.valid        = valid_s2;
	assign res.alu_result   = res_s2.alu_result;
	assign res.cond_true    = res_s2.cond_true;
	assign res.dest_out     = res_s2.dest_out;
	assign res.zero_out     = res_s2.flags.zero;
	assign res.sign_out     = res_s2.flags.sign;
	assign res.overflow_out = res_s2.flags.overflow;

	// flags only change when an unheld op instruction leaves s1
	`ASSERT_NEXT(a_flags_stable, clk, arst_n,
		!(advance && (item_s1.opcode == OP_ALU) && !item_s1.hold_flags),
		$stable(flag_q), "flags changed without an op instruction")
	// reported flags match the architectural flags
	`ASSERT_SAME(a_flags_match, clk, arst_n, valid_s2, res_s2.flags == flag_q,
		"result flags differ from stored flags")
	// a failed conditional move cancels its destination
	`ASSERT_NEXT(a_cmov_cancel, clk, arst_n,
		advance && (item_s1.opcode == OP_CMOV) && !res_nxt.cond_true,
		res_s2.dest_out == REG_NONE, "failed cmov kept its destination")
	// an item in s1 is never dropped
	`ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !advance, valid_s1,
		"s1 item lost while stalled")

endmodule

`default_nettype wire

// File: sim/pipeline_execute_alu_cc_tb.sv
`timescale 1ns / 1ps

module pipeline_execute_alu_cc_tb;
	import pexa_pkg::*;

	localparam int RAND_ITEMS  = 650;
	localparam int STALL_LIMIT = 1000;  // cycles with no item moving on either side
	localparam int DRAIN_WAIT  = 8;     // margin after the last result for strays

	// Tracks the execute stage: own copy of the condition flags, queue of
	// expected result items, mismatch count and a few coverage tallies.
	class execute_scoreboard;
		flags_t  cc_flags;
		result_t expected_results[$];
		int      mismatches;
		int      n_checked;
		int      n_alu;
		int      n_cmov_cancelled;
		int      n_jump_taken;

		function new();
			cc_flags = '0;
			mismatches = 0;
			n_checked = 0;
			n_alu = 0;
			n_cmov_cancelled = 0;
			n_jump_taken = 0;
		endfunction

		// Condition test against the stored flags; codes above G never pass.
		function logic cond_holds(logic [3:0] cc);
			logic lt;
			lt = cc_flags.sign ^ cc_flags.overflow;
			case (cc)
				CC_ALWAYS: return 1'b1;
				CC_LE:     return lt | cc_flags.zero;
				CC_L:      return lt;
				CC_E:      return cc_flags.zero;
				CC_NE:     return ~cc_flags.zero;
				CC_GE:     return ~lt;
				CC_G:      return ~lt & ~cc_flags.zero;
				default:   return 1'b0;
			endcase
		endfunction

		// One instruction through the ALU and flag logic; updates cc_flags.
		function result_t execute_insn(item_t it);
			logic [63:0] opa;
			logic [63:0] opb;
			logic [63:0] sum;
			logic [3:0]  fn;
			result_t     res;
			opa = '0;
			opb = '0;
			fn = FN_ADD;
			case (it.opcode)
				OP_CMOV, OP_ALU:              opa = it.reg_value_a;
				OP_IRMOV, OP_RMMOV, OP_MRMOV: opa = it.const_word;
				OP_CALL, OP_PUSH:             opa = STACK_DOWN;
				OP_RET, OP_POP:               opa = STACK_UP;
				default: ;
			endcase
			case (it.opcode)
				OP_RMMOV, OP_MRMOV, OP_ALU, OP_CALL, OP_RET, OP_PUSH, OP_POP:
					opb = it.reg_value_b;
				default: ;
			endcase
			if (it.opcode == OP_ALU)
				fn = it.func_code;
			case (fn)
				FN_ADD:  sum = opb + opa;
				FN_SUB:  sum = opb - opa;
				FN_AND:  sum = opb & opa;
				FN_XOR:  sum = opb ^ opa;
				default: sum = '0;
			endcase
			if (it.opcode == OP_ALU && !it.hold_flags) begin
				cc_flags.zero = (sum == '0);
				cc_flags.sign = sum[63];
				if (fn == FN_ADD)
					cc_flags.overflow = (opa[63] == opb[63]) && (sum[63] != opa[63]);
				else if (fn == FN_SUB)
					cc_flags.overflow = (opb[63] != opa[63]) && (sum[63] != opb[63]);
				else
					cc_flags.overflow = 1'b0;
			end
			res.alu_result = sum;
			res.cond_true = (it.opcode == OP_CMOV || it.opcode == OP_JUMP) ?
				cond_holds(it.func_code) : 1'b0;
			res.dest_out = (it.opcode == OP_CMOV && !res.cond_true) ? REG_NONE : it.dest_in;
			res.flags = cc_flags;
			if (it.opcode == OP_ALU)
				n_alu++;
			if (it.opcode == OP_CMOV && !res.cond_true)
				n_cmov_cancelled++;
			if (it.opcode == OP_JUMP && res.cond_true)
				n_jump_taken++;
			return res;
		endfunction

		function void note_insn(item_t it);
			expected_results = {expected_results, execute_insn(it)};
		endfunction

		task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
			$display("%0t ns: MISMATCH %s: got %h, expected %h", $time, what, got, want);
			mismatches++;
		endtask

		task check_result(result_t got);
			result_t want;
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result item", got.alu_result, '0);
				return;
			end
			want = expected_results.pop_front();
			n_checked++;
			if (got.alu_result !== want.alu_result)
				report_mismatch("alu_result", got.alu_result, want.alu_result);
			if (got.cond_true !== want.cond_true)
				report_mismatch("cond_true", 64'(got.cond_true), 64'(want.cond_true));
			if (got.dest_out !== want.dest_out)
				report_mismatch("dest_out", 64'(got.dest_out), 64'(want.dest_out));
			if (got.flags.zero !== want.flags.zero)
				report_mismatch("zero_out", 64'(got.flags.zero), 64'(want.flags.zero));
			if (got.flags.sign !== want.flags.sign)
				report_mismatch("sign_out", 64'(got.flags.sign), 64'(want.flags.sign));
			if (got.flags.overflow !== want.flags.overflow)
				report_mismatch("overflow_out", 64'(got.flags.overflow),
					64'(want.flags.overflow));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic calm = 1'b0;      // no idling on either side while set
	int   stall_cycles = 0;

	execute_scoreboard sb = new();

	pexa_insn_if insn_ch ();
	pexa_res_if  res_ch ();

	pipeline_execute_alu_cc i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.insn   (insn_ch),
		.res    (res_ch)
	);

	always #1 clk = ~clk;

	// Monitor: both channels are sampled at the edge, before the DUT's own
	// updates land. Results are checked before the new item is noted so a
	// same-edge pair never sees a prediction it should not.
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready)
				sb.check_result({res_ch.alu_result, res_ch.cond_true, res_ch.dest_out,
					res_ch.zero_out, res_ch.sign_out, res_ch.overflow_out});
			if (insn_ch.valid && insn_ch.ready)
				sb.note_insn({insn_ch.opcode, insn_ch.func_code, insn_ch.reg_value_a,
					insn_ch.reg_value_b, insn_ch.const_word, insn_ch.dest_in,
					insn_ch.hold_flags});
			if ((res_ch.valid && res_ch.ready) || (insn_ch.valid && insn_ch.ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
		end
	end

	// Watchdog: nothing moving for too long means a hang.
	initial begin
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("watchdog: %0d cycles with no item accepted", STALL_LIMIT);
		$display("pipeline_execute_alu_cc_tb: errors");
		$finish;
	end

	// Result side: ready drops about a third of the time, except when calm.
	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			res_ch.ready <= arst_n && (calm || $urandom_range(99) >= 34);
		end
	end

	function automatic item_t make_insn(logic [3:0] op, logic [3:0] fn, logic [63:0] a,
			logic [63:0] b, logic [63:0] k, logic [3:0] dest, logic hold);
		item_t it;
		it.opcode = op;
		it.func_code = fn;
		it.reg_value_a = a;
		it.reg_value_b = b;
		it.const_word = k;
		it.dest_in = dest;
		it.hold_flags = hold;
		return it;
	endfunction

	// Operand mix weighted toward the corners that move the flags.
	function automatic logic [63:0] rand_word();
		case ($urandom_range(7))
			0:       return 64'h0;
			1:       return 64'hFFFF_FFFF_FFFF_FFFF;
			2:       return 64'h8000_0000_0000_0000;
			3:       return 64'h7FFF_FFFF_FFFF_FFFF;
			4:       return 64'($urandom_range(16));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Optional random gap, then hold the item until it is taken.
	task automatic send_insn(item_t it);
		if (!calm && $urandom_range(99) < 34) begin
			insn_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		insn_ch.valid       <= 1'b1;
		insn_ch.opcode      <= it.opcode;
		insn_ch.func_code   <= it.func_code;
		insn_ch.reg_value_a <= it.reg_value_a;
		insn_ch.reg_value_b <= it.reg_value_b;
		insn_ch.const_word  <= it.const_word;
		insn_ch.dest_in     <= it.dest_in;
		insn_ch.hold_flags  <= it.hold_flags;
		@(posedge clk);
		while (!insn_ch.ready)
			@(posedge clk);
	endtask

	initial begin
		item_t directed[$];
		item_t it;
		int    pick;
		logic [63:0] ones;
		logic [63:0] min_neg;
		logic [63:0] max_pos;

		ones    = 64'hFFFF_FFFF_FFFF_FFFF;
		min_neg = 64'h8000_0000_0000_0000;
		max_pos = 64'h7FFF_FFFF_FFFF_FFFF;

		insn_ch.valid       <= 1'b0;
		insn_ch.opcode      <= '0;
		insn_ch.func_code   <= '0;
		insn_ch.reg_value_a <= '0;
		insn_ch.reg_value_b <= '0;
		insn_ch.const_word  <= '0;
		insn_ch.dest_in     <= '0;
		insn_ch.hold_flags  <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ALU ops: wrap to zero, signed overflow both ways, logic ops,
		// function codes above XOR, and a held flag update.
		directed = {directed, make_insn(OP_ALU, FN_ADD, 64'd1, ones, ones, 4'd0, 1'b0)};
		directed = {directed, make_insn(OP_ALU, FN_ADD, 64'd1, max_pos, '0, 4'd1, 1'b0)};
		directed = {directed, make_insn(OP_ALU, FN_SUB, 64'd1, min_neg, '0, 4'd2, 1'b0)};
		directed = {directed, make_insn(OP_ALU, FN_AND, ones, 64'h00FF_00FF_00FF_00FF,
			'0, 4'd3, 1'b0)};
		directed = {directed, make_insn(OP_ALU, FN_XOR, ones, ones, '0, 4'd14, 1'b0)};
		directed = {directed, make_insn(OP_ALU, 4'd4, ones, ones, ones, 4'd5, 1'b0)};
		directed = {directed, make_insn(OP_ALU, FN_SUB, 64'd5, 64'd2, '0, 4'd6, 1'b1)};
		directed = {directed, make_insn(OP_ALU, 4'd15, ones, min_neg, '0, 4'd15, 1'b1)};
		// Every condition against zero-set flags, cmov and jump interleaved;
		// codes above G must fail and cancel the cmov destination.
		for (int cc = 0; cc <= 6; cc++)
			directed = {directed, make_insn((cc % 2) ? OP_JUMP : OP_CMOV, 4'(cc),
				ones, ones, ones, 4'(cc + 7), 1'b0)};
		directed = {directed, make_insn(OP_CMOV, 4'd7, ones, '0, '0, 4'd9, 1'b0)};
		directed = {directed, make_insn(OP_JUMP, 4'd15, ones, ones, ones, 4'd3, 1'b0)};
		// Operand routing for the move, memory and stack instructions.
		directed = {directed, make_insn(OP_IRMOV, 4'd0, ones, ones, max_pos, 4'd4, 1'b0)};
		directed = {directed, make_insn(OP_RMMOV, 4'd0, ones, 64'h1000, 64'h20, 4'd15,
			1'b0)};
		directed = {directed, make_insn(OP_MRMOV, 4'd0, '0, ones, ones, 4'd8, 1'b0)};
		directed = {directed, make_insn(OP_CALL, 4'd0, ones, 64'd4, ones, 4'd4, 1'b0)};
		directed = {directed, make_insn(OP_RET, 4'd0, ones, ones, ones, 4'd4, 1'b0)};
		directed = {directed, make_insn(OP_PUSH, 4'd0, '0, '0, '0, 4'd4, 1'b1)};
		directed = {directed, make_insn(OP_POP, 4'd0, ones, min_neg, '0, 4'd4, 1'b0)};
		// Unused opcodes: zero result, flags untouched.
		directed = {directed, make_insn(4'd0, 4'd3, ones, ones, ones, 4'd10, 1'b0)};
		directed = {directed, make_insn(4'd1, 4'd0, ones, ones, ones, 4'd11, 1'b1)};
		directed = {directed, make_insn(4'd12, 4'd1, ones, ones, ones, 4'd12, 1'b0)};
		directed = {directed, make_insn(4'd15, 4'd15, ones, ones, ones, 4'd15, 1'b0)};

		foreach (directed[i])
			send_insn(directed[i]);

		// Random part: mostly ALU ops, cmovs and jumps so the flags keep
		// changing under the conditions, plus any opcode at all.
		for (int n = 0; n < RAND_ITEMS; n++) begin
			pick = $urandom_range(99);
			if (pick < 35)
				it.opcode = OP_ALU;
			else if (pick < 58)
				it.opcode = OP_CMOV;
			else if (pick < 72)
				it.opcode = OP_JUMP;
			else
				it.opcode = 4'($urandom_range(15));
			if (it.opcode == OP_ALU)
				it.func_code = ($urandom_range(99) < 85) ? 4'($urandom_range(3)) :
					4'($urandom_range(15, 4));
			else if (it.opcode == OP_CMOV || it.opcode == OP_JUMP)
				it.func_code = ($urandom_range(99) < 85) ? 4'($urandom_range(6)) :
					4'($urandom_range(15, 7));
			else
				it.func_code = 4'($urandom_range(15));
			it.reg_value_a = rand_word();
			it.reg_value_b = ($urandom_range(9) == 0) ? it.reg_value_a : rand_word();
			it.const_word  = rand_word();
			it.dest_in     = 4'($urandom_range(15));
			it.hold_flags  = ($urandom_range(99) < 15);
			calm = (n >= 250 && n < 400);
			send_insn(it);
		end
		calm = 1'b0;
		insn_ch.valid <= 1'b0;

		// every sent item must come back; the watchdog covers a hang
		while (sb.n_checked < directed.size() + RAND_ITEMS)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("covered %0d instructions: %0d ALU ops, %0d cancelled cmovs, %0d taken jumps",
			sb.n_checked, sb.n_alu, sb.n_cmov_cancelled, sb.n_jump_taken);
		$display("field mismatches seen: %0d", sb.mismatches);
		if (sb.mismatches == 0)
			$display("pipeline_execute_alu_cc_tb: clean");
		else
			$display("pipeline_execute_alu_cc_tb: errors");
		$finish;
	end

endmodule
